>>> sv/log_band_bar_meter_unit_macros.svh
// ----------------------------------------------------------------------------
// log_band_bar_meter_unit_macros.svh
// Assertion macros shared by the bar meter checkers.
// ----------------------------------------------------------------------------
`ifndef LOG_BAND_BAR_METER_UNIT_MACROS_SVH
`define LOG_BAND_BAR_METER_UNIT_MACROS_SVH

// same-cycle implication under active-low reset
`define LBBM_AST_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bar meter check failed");

// next-cycle implication under active-low reset
`define LBBM_AST_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bar meter check failed");

`endif

>>> sv/lbbm_pkg.sv
// ----------------------------------------------------------------------------
// lbbm_pkg
// Widths, register codes, bar width table and shared types of the bar meter.
// ----------------------------------------------------------------------------
`default_nettype none

package lbbm_pkg;

	localparam int BAR_COUNT  = 32;
	localparam int BAR_W      = $clog2(BAR_COUNT);
	localparam int EXP_W      = BAR_W - 1;
	localparam int IDX_OUT_W  = 5;
	localparam int SAMPLE_W   = 24;
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 8;
	localparam int PEAK_W     = 24;
	localparam int DEN_W      = 24;
	localparam int HGT_W      = 17;
	localparam int RATIO_W    = 17;
	localparam int RATIO_FRAC = 15;
	localparam int SHIFT_W    = 3;
	localparam int FLOOR_W    = 23;
	localparam int STEP_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = CFG_IDX_W'(1);

	localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(3);
	localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(4096);

	localparam logic [STEP_W-1:0] AVG_STEPS   = STEP_W'(SUM_W);
	localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(RATIO_FRAC);

	localparam logic [BAR_W-1:0] HALF_BAR = BAR_W'(BAR_COUNT / 2);
	localparam logic [BAR_W-1:0] LAST_BAR = BAR_W'(BAR_COUNT - 1);

	localparam logic [CNT_W-1:0] POW_WIDTHS [2**EXP_W] = '{
		8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd8, 8'd11,
		8'd16, 8'd21, 8'd29, 8'd40, 8'd55, 8'd75, 8'd102, 8'd138
	};

	typedef struct packed {
		logic signed [PEAK_W-1:0] peak;
		logic signed [HGT_W-1:0]  height;
	} ram_word_t;

	typedef struct packed {
		logic [SUM_W-1:0]  num;
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	function automatic logic [CNT_W-1:0] bar_width(input logic [BAR_W-1:0] bar);
		logic [BAR_W-1:0] e_m1;
		if (bar < HALF_BAR) begin
			e_m1 = HALF_BAR - bar - BAR_W'(1);
		end else begin
			e_m1 = bar - HALF_BAR;
		end
		return POW_WIDTHS[e_m1[EXP_W-1:0]];
	endfunction

endpackage

`default_nettype wire

>>> sv/lbbm_in_if.sv
// ----------------------------------------------------------------------------
// lbbm_in_if
// Sample channel: one sample item with its frame start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbbm_in_if;
	import lbbm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       frame_start;

	modport source (output valid, output sample, output frame_start, input ready);
	modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

`default_nettype wire

>>> sv/lbbm_out_if.sv
// ----------------------------------------------------------------------------
// lbbm_out_if
// Result channel: one bar height item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbbm_out_if;
	import lbbm_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [IDX_OUT_W-1:0]        bar_index;
	logic signed [HGT_W-1:0]     bar_height;
	logic                        last_bar;

	modport source (output valid, output bar_index, output bar_height, output last_bar,
		input ready);
	modport sink   (input valid, input bar_index, input bar_height, input last_bar,
		output ready);
endinterface

`default_nettype wire

>>> sv/lbbm_cfg_if.sv
// ----------------------------------------------------------------------------
// lbbm_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbbm_cfg_if;
	import lbbm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/lbbm_ram.sv
// ----------------------------------------------------------------------------
// lbbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbm_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

>>> sv/lbbm_div.sv
// ----------------------------------------------------------------------------
// lbbm_div
// Restoring divider, one quotient bit per cycle, with preloadable remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbm_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  lbbm_pkg::div_req_t       req,
	output logic                     done,
	output logic [lbbm_pkg::SUM_W-1:0] quo
);
	import lbbm_pkg::*;

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [SUM_W-1:0]  quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= req.rem;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= req.steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

`default_nettype wire

>>> sv/log_band_bar_meter_unit.sv
// ----------------------------------------------------------------------------
// log_band_bar_meter_unit
// Groups a frame of samples into log-width bars and emits one smoothed,
// peak-normalized height item per closed bar.
// Channels: smp takes one sample item per handshake (frame_start restarts at
// bar 0); res gives bar_index, bar_height and last_bar; cfg writes register 0
// (smoothing shift) or 1 (peak floor, reloads every bar's peak-hold).
// A sample that does not close a bar leaves the input ready for the next item.
// A closing sample holds the input while its bar is worked: load, averaging
// divide, peak step, ratio check, ratio divide on the shared bit-serial
// divider, write-back and output. The ratio divide is skipped when the ratio
// saturates or the peak is zero, so that result is valid sooner.
// Peak-hold and height live in one 32-entry RAM; per-entry valid bits stand
// in for the reset values, so no clearing pass is needed after reset.
// Reset clears the bar position, the valid bits and the output register.
// A stalled receiver holds the result; samples are still taken until the next
// bar closes, and that bar's result then holds off the input until the output
// register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module log_band_bar_meter_unit (
	input  logic       clk,
	input  logic       arst_n,
	lbbm_in_if.sink    smp,
	lbbm_out_if.source res,
	lbbm_cfg_if.sink   cfg
);
	import lbbm_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_AVG    = 3'd2;
	localparam logic [2:0] ST_PEAK   = 3'd3;
	localparam logic [2:0] ST_RATIO  = 3'd4;
	localparam logic [2:0] ST_NORM   = 3'd5;
	localparam logic [2:0] ST_SMOOTH = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0]               state_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [BAR_W-1:0]         bar_q;
	logic                     fin_q;
	logic                     sum_neg_q;
	logic [SHIFT_W-1:0]       shift_q;
	logic [FLOOR_W-1:0]       floor_q;
	logic [BAR_COUNT-1:0]     peak_vld_q;
	logic [BAR_COUNT-1:0]     hgt_vld_q;
	logic signed [PEAK_W-1:0] avg_q;
	logic [PEAK_W-1:0]        avg_mag_q;
	logic signed [PEAK_W-1:0] peak_q;
	logic signed [RATIO_W-1:0] ratio_q;
	logic signed [HGT_W-1:0]  hgt_q;
	logic                     out_valid_q;
	logic [IDX_OUT_W-1:0]     out_idx_q;
	logic signed [HGT_W-1:0]  out_hgt_q;
	logic                     out_last_q;

	logic                     in_acc;
	logic signed [SUM_W-1:0]  sum_base;
	logic signed [SUM_W-1:0]  sum_add;
	logic [CNT_W-1:0]         cnt_base;
	logic [BAR_W-1:0]         bar_base;
	logic                     fin_base;
	logic                     closes;
	logic [SUM_W-1:0]         sum_mag;
	logic                     div_start;
	div_req_t                 div_req;
	logic                     div_done;
	logic [SUM_W-1:0]         div_quo;
	logic signed [PEAK_W-1:0] avg_next;
	ram_word_t                rd_word;
	ram_word_t                wr_word;
	logic [$bits(ram_word_t)-1:0] ram_rdata;
	logic                     ram_we;
	logic signed [PEAK_W-1:0] peak_old;
	logic signed [RATIO_W-1:0] ratio_div;
	logic signed [HGT_W-1:0]  h_old;
	logic signed [HGT_W:0]    target;
	logic signed [HGT_W+1:0]  err;
	logic signed [HGT_W+1:0]  step;
	logic signed [HGT_W+2:0]  h_sum;
	logic signed [HGT_W-1:0]  h_new;
	logic                     out_free;

	assign in_acc   = smp.valid && smp.ready;
	assign sum_base = smp.frame_start ? '0 : sum_q;
	assign cnt_base = smp.frame_start ? '0 : cnt_q;
	assign bar_base = smp.frame_start ? '0 : bar_q;
	assign fin_base = smp.frame_start ? 1'b0 : fin_q;
	assign sum_add  = sum_base + SUM_W'(smp.sample);
	assign closes   = (cnt_base + CNT_W'(1)) == bar_width(bar_base);

	assign sum_mag  = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	assign avg_next = sum_neg_q ? -PEAK_W'(div_quo) : PEAK_W'(div_quo);

	always_comb begin
		div_start = 1'b0;
		div_req   = '0;
		if (state_q == ST_LOAD) begin
			div_start   = 1'b1;
			div_req.num = sum_mag;
			div_req.den = DEN_W'(bar_width(bar_q));
			div_req.steps = AVG_STEPS;
		end else if (state_q == ST_RATIO && peak_q != '0
				&& avg_mag_q < PEAK_W'(peak_q)) begin
			div_start   = 1'b1;
			div_req.rem = avg_mag_q;
			div_req.den = peak_q;
			div_req.steps = RATIO_STEPS;
		end
	end

	lbbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign rd_word  = ram_word_t'(ram_rdata);
	assign peak_old = peak_vld_q[bar_q] ? rd_word.peak : $signed({1'b0, floor_q});
	assign ratio_div = $signed({2'b00, div_quo[RATIO_FRAC-1:0]});

	assign h_old  = hgt_vld_q[bar_q] ? rd_word.height : '0;
	assign target = {ratio_q, 1'b0};
	assign err    = (HGT_W+2)'(target) - (HGT_W+2)'(h_old);
	assign step   = err >>> shift_q;
	assign h_sum  = (HGT_W+3)'(h_old) + (HGT_W+3)'(step);

	always_comb begin
		if (h_sum > (HGT_W+3)'(65535)) begin
			h_new = HGT_W'(65535);
		end else if (h_sum < -(HGT_W+3)'(65536)) begin
			h_new = -HGT_W'(65536);
		end else begin
			h_new = h_sum[HGT_W-1:0];
		end
	end

	assign ram_we         = (state_q == ST_SMOOTH);
	assign wr_word.peak   = peak_q;
	assign wr_word.height = h_new;

	lbbm_ram #(
		.W ($bits(ram_word_t)),
		.D (BAR_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bar_q),
		.wdata (wr_word),
		.raddr (bar_q),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_AVG: begin
				if (div_done) begin
					avg_q <= avg_next;
				end
			end
			ST_PEAK: begin
				peak_q    <= (avg_q > peak_old) ? avg_q : peak_old;
				avg_mag_q <= avg_q[PEAK_W-1] ? PEAK_W'(-avg_q) : PEAK_W'(avg_q);
			end
			ST_RATIO: begin
				if (peak_q == '0) begin
					ratio_q <= (avg_mag_q == '0) ? '0 : -RATIO_W'(32768);
				end else if (avg_mag_q >= PEAK_W'(peak_q)) begin
					ratio_q <= avg_q[PEAK_W-1] ? -RATIO_W'(32768) : RATIO_W'(32768);
				end
			end
			ST_NORM: begin
				if (div_done) begin
					ratio_q <= avg_q[PEAK_W-1] ? -ratio_div : ratio_div;
				end
			end
			ST_SMOOTH: begin
				hgt_q <= h_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			bar_q       <= '0;
			fin_q       <= 1'b0;
			sum_neg_q   <= 1'b0;
			shift_q     <= SHIFT_RST;
			floor_q     <= FLOOR_RST;
			peak_vld_q  <= '0;
			hgt_vld_q   <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_hgt_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_SMOOTH: shift_q <= cfg.data[SHIFT_W-1:0];
					CFG_FLOOR: begin
						floor_q    <= cfg.data[FLOOR_W-1:0];
						peak_vld_q <= '0;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						bar_q <= bar_base;
						fin_q <= fin_base;
						if (fin_base) begin
							sum_q <= sum_base;
							cnt_q <= cnt_base;
						end else if (closes) begin
							sum_q   <= sum_add;
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							sum_q <= sum_add;
							cnt_q <= cnt_base + CNT_W'(1);
						end
					end
				end
				ST_LOAD: begin
					sum_neg_q <= sum_q[SUM_W-1];
					sum_q     <= '0;
					state_q   <= ST_AVG;
				end
				ST_AVG: begin
					if (div_done) begin
						state_q <= ST_PEAK;
					end
				end
				ST_PEAK: begin
					state_q <= ST_RATIO;
				end
				ST_RATIO: begin
					state_q <= div_start ? ST_NORM : ST_SMOOTH;
				end
				ST_NORM: begin
					if (div_done) begin
						state_q <= ST_SMOOTH;
					end
				end
				ST_SMOOTH: begin
					peak_vld_q[bar_q] <= 1'b1;
					hgt_vld_q[bar_q]  <= 1'b1;
					state_q           <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= IDX_OUT_W'(bar_q);
						out_hgt_q   <= hgt_q;
						out_last_q  <= (bar_q == LAST_BAR);
						fin_q       <= (bar_q == LAST_BAR);
						bar_q       <= bar_q + BAR_W'(1);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign smp.ready      = (state_q == ST_IDLE);
	assign cfg.ready      = 1'b1;
	assign res.valid      = out_valid_q;
	assign res.bar_index  = out_idx_q;
	assign res.bar_height = out_hgt_q;
	assign res.last_bar   = out_last_q;
endmodule

`default_nettype wire

>>> sv/lbbm_chk.sv
// ----------------------------------------------------------------------------
// lbbm_chk
// Port-level checks of the bar meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "log_band_bar_meter_unit_macros.svh"

module lbbm_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lbbm_pkg::IDX_OUT_W-1:0] bar_index,
	input logic [lbbm_pkg::HGT_W-1:0]    bar_height,
	input logic                          last_bar
);
	import lbbm_pkg::*;

	`LBBM_AST_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(bar_index) && $stable(bar_height) && $stable(last_bar))
	`LBBM_AST_IMP(a_last_index, clk, arst_n, out_valid && last_bar, bar_index == IDX_OUT_W'(BAR_COUNT - 1))
	`LBBM_AST_IMP(a_res_after_work, clk, arst_n, $rose(out_valid), $past(!in_ready))
endmodule

bind log_band_bar_meter_unit lbbm_chk u_lbbm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (smp.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.bar_index  (res.bar_index),
	.bar_height (res.bar_height),
	.last_bar   (res.last_bar)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the log-band bar meter. A queue-fed driver offers
// sample items, a clocked monitor bins every accepted item in a local model
// of the bars, peak-holds and smoothed heights, and compares each bar height
// item field by field. Register settings change between phases while the
// block is idle; both channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
	import lbbm_pkg::*;

	localparam int FRAME_LEN     = 2048;
	localparam int RAND_ITEMS    = 1100;
	localparam int QUIET_FROM    = 1000;
	localparam int LONG_HOLD     = 3000;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 100;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = CFG_IDX_W'(3);

	localparam int BAND_LEN [16] = '{
		1, 1, 2, 3, 4, 6, 8, 11, 16, 21, 29, 40, 55, 75, 102, 138
	};

	localparam logic [SAMPLE_W:0] DIRECTED [14] = '{
		{1'b0, 24'h7FFFFF}, {1'b0, 24'h800000}, {1'b1, 24'h000000}, {1'b0, 24'hFFFFFF},
		{1'b0, 24'h555555}, {1'b0, 24'hAAAAAA}, {1'b1, 24'h7FFFFF}, {1'b0, 24'h7FFFFF},
		{1'b1, 24'h800000}, {1'b0, 24'h800000}, {1'b1, 24'h000001}, {1'b1, 24'hFFFFFF},
		{1'b0, 24'h000001}, {1'b0, 24'h000000}
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       starts;
	} sample_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0]    bar_index;
		logic signed [HGT_W-1:0] bar_height;
		logic                    last_bar;
	} bar_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lbbm_in_if  smp ();
	lbbm_out_if res ();
	lbbm_cfg_if cfg ();

	log_band_bar_meter_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.res    (res),
		.cfg    (cfg)
	);

	sample_item_t sample_queue [$];
	bar_result_t  height_due [$];
	sample_item_t next_item;
	bar_result_t  got_want;

	logic [SHIFT_W-1:0] shift_reg;
	logic [FLOOR_W-1:0] floor_reg;
	longint             acc_sum;
	int                 acc_cnt;
	int                 open_bar;
	int                 frame_pos;
	bit                 frame_done;
	int                 peak_track [BAR_COUNT];
	int                 height_track [BAR_COUNT];

	bit smp_taken = 1'b0;
	bit failed = 1'b0;
	bit idle_on = 1'b1;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int tx_gap = 0;
	int rx_gap = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int band_len(int b);
		int e;
		e = (b < BAR_COUNT / 2) ? BAR_COUNT / 2 - 1 - b : b - BAR_COUNT / 2;
		return BAND_LEN[e & 15];
	endfunction

	task automatic bin_sample(input logic signed [SAMPLE_W-1:0] value, input logic starts);
		longint      avg;
		longint      ratio;
		int          w;
		int          target;
		int          h;
		bar_result_t r;
		if (starts) begin
			acc_sum = 0;
			acc_cnt = 0;
			open_bar = 0;
			frame_pos = 0;
			frame_done = 1'b0;
		end
		if (frame_done || open_bar >= BAR_COUNT || frame_pos >= FRAME_LEN)
			return;
		frame_pos++;
		acc_sum += value;
		acc_cnt++;
		w = band_len(open_bar);
		if (acc_cnt < w)
			return;
		avg = acc_sum / w;
		if (avg > peak_track[open_bar])
			peak_track[open_bar] = int'(avg);
		if (peak_track[open_bar] <= 0) begin
			ratio = (avg == 0) ? 0 : -32768;
		end else begin
			ratio = (avg * 32768) / peak_track[open_bar];
			if (ratio > 32768)
				ratio = 32768;
			if (ratio < -32768)
				ratio = -32768;
		end
		target = int'(ratio * 2);
		h = height_track[open_bar] + ((target - height_track[open_bar]) >>> shift_reg);
		if (h > 65535)
			h = 65535;
		if (h < -65536)
			h = -65536;
		height_track[open_bar] = h;
		r.bar_index = open_bar[IDX_OUT_W-1:0];
		r.bar_height = h[HGT_W-1:0];
		r.last_bar = (open_bar == BAR_COUNT - 1);
		height_due.push_back(r);
		acc_sum = 0;
		acc_cnt = 0;
		open_bar++;
		if (open_bar >= BAR_COUNT)
			frame_done = 1'b1;
	endtask

	always @(posedge clk) begin
		smp_taken <= arst_n && smp.valid && smp.ready;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SMOOTH: shift_reg = cfg.data[SHIFT_W-1:0];
					CFG_FLOOR: begin
						floor_reg = cfg.data[FLOOR_W-1:0];
						for (int i = 0; i < BAR_COUNT; i++)
							peak_track[i] = int'(floor_reg);
					end
					default: ;
				endcase
			end
			if (smp.valid && smp.ready)
				bin_sample(smp.sample, smp.frame_start);
			if (res.valid && res.ready) begin
				if (height_due.size() == 0) begin
					$error("unexpected bar height item: bar_index %0d, bar_height %0d",
						res.bar_index, res.bar_height);
					failed = 1'b1;
				end else begin
					got_want = height_due.pop_front();
					if (res.bar_index !== got_want.bar_index) begin
						$error("bar_index: expected %0d, actual %0d",
							got_want.bar_index, res.bar_index);
						failed = 1'b1;
					end
					if (res.bar_height !== got_want.bar_height) begin
						$error("bar_height: expected %0d, actual %0d",
							$signed(got_want.bar_height), res.bar_height);
						failed = 1'b1;
					end
					if (res.last_bar !== got_want.last_bar) begin
						$error("last_bar: expected %0d, actual %0d",
							got_want.last_bar, res.last_bar);
						failed = 1'b1;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else if (!smp.valid || smp_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				smp.valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				next_item = sample_queue.pop_front();
				smp.valid <= 1'b1;
				smp.sample <= next_item.value;
				smp.frame_start <= next_item.starts;
				if (idle_on && !quiet && $urandom_range(0, 5) == 0)
					tx_gap = $urandom_range(1, 9);
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			res.ready <= 1'b0;
		end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(1, 9) - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	task automatic queue_samples(input int len, input bit starts);
		sample_item_t       item;
		logic [SAMPLE_W-1:0] val;
		int                 mode;
		int                 level;
		mode = 0;
		level = 0;
		for (int k = 0; k < len; k++) begin
			if (k == 0 || $urandom_range(0, 49) == 0) begin
				mode = $urandom_range(0, 3);
				level = $signed($urandom()) >>> $urandom_range(8, 31);
			end
			case (mode)
				0: val = SAMPLE_W'($urandom());
				1: val = SAMPLE_W'(level + int'($urandom_range(0, 511)) - 256);
				2: begin
					case ($urandom_range(0, 4))
						0: val = 24'h7FFFFF;
						1: val = 24'h800000;
						2: val = 24'h000000;
						3: val = 24'hFFFFFF;
						default: val = 24'h000001;
					endcase
				end
				default: val = SAMPLE_W'(level + int'($urandom_range(0, 65535)) - 32768);
			endcase
			item.value = val;
			item.starts = starts && (k == 0);
			sample_queue.push_back(item);
		end
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		while (sample_queue.size() != 0 || smp.valid)
			@(posedge clk);
		while (height_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (height_due.size() != 0) begin
			$error("bar heights never delivered: %0d outstanding", height_due.size());
			failed = 1'b1;
		end
	endtask

	initial begin
		sample_item_t       item;
		int                 phase;
		int                 counted;
		int                 full_len;
		int                 chunk;
		logic [SHIFT_W-1:0] shift_v;
		logic [FLOOR_W-1:0] floor_v;

		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.sample = '0;
		smp.frame_start = 1'b0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_SMOOTH;
		cfg.data = '0;
		shift_reg = SHIFT_RST;
		floor_reg = FLOOR_RST;
		acc_sum = 0;
		acc_cnt = 0;
		open_bar = 0;
		frame_pos = 0;
		frame_done = 1'b0;
		for (int i = 0; i < BAR_COUNT; i++) begin
			peak_track[i] = int'(FLOOR_RST);
			height_track[i] = 0;
		end
		full_len = 0;
		for (int b = 0; b < BAR_COUNT; b++)
			full_len += band_len(b);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			item.value = DIRECTED[i][SAMPLE_W-1:0];
			item.starts = DIRECTED[i][SAMPLE_W];
			sample_queue.push_back(item);
		end

		phase = 0;
		counted = 0;
		while (phase < 4 || counted < RAND_ITEMS) begin
			settle();
			case (phase)
				0: begin
					shift_v = '0;
					floor_v = FLOOR_W'(1);
				end
				1: begin
					shift_v = '1;
					floor_v = '1;
				end
				2: begin
					shift_v = SHIFT_W'($urandom_range(0, 7));
					floor_v = '0;
				end
				default: begin
					shift_v = SHIFT_W'($urandom_range(0, 7));
					floor_v = ($urandom_range(0, 2) == 0) ?
						FLOOR_W'($urandom_range(1, 65536)) : FLOOR_W'($urandom());
				end
			endcase
			write_reg(CFG_SMOOTH, CFG_DATA_W'(shift_v));
			write_reg(CFG_FLOOR, floor_v);
			if (phase == 0 || $urandom_range(0, 2) == 0) begin
				write_reg(CFG_UNMAPPED_A, CFG_DATA_W'($urandom()));
				write_reg(CFG_UNMAPPED_B, CFG_DATA_W'($urandom()));
			end
			@(negedge clk);
			cfg.valid <= 1'b0;
			@(posedge clk);

			quiet = (counted >= QUIET_FROM);
			idle_on = (phase == 0) || ($urandom_range(0, 3) != 0);
			if (phase == 0)
				hold_req = 1'b1;

			if (phase == 0) begin
				chunk = $urandom_range(250, 400);
				queue_samples(chunk, 1'b1);
			end else if (phase == 1) begin
				chunk = $urandom_range(200, 400);
				queue_samples(chunk, 1'b0);
			end else if (phase == 2) begin
				chunk = full_len - counted + int'($urandom_range(1, 6));
				queue_samples(chunk, 1'b0);
			end else begin
				chunk = $urandom_range(20, 60);
				queue_samples(chunk, 1'b1);
			end
			counted += chunk;
			phase++;
		end

		settle();
		if (!failed) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
